/* src/assert_macros.svh */
// Assertion macros shared by the detector RTL.
// Depends on a clock named clk and an active-high synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising clock edge, switched off while reset is high.
`define QSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("qsd assertion failed");
// Checked at every rising clock edge, reset included.
`define QSD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("qsd assertion failed");
`else
`define QSD_ASSERT(label, prop)
`define QSD_ASSERT_ALWAYS(label, prop)
`endif

`endif

/* src/qsd_pkg.sv */
// Package for the quadrature sampling detector: widths, types, register codes
// and the Johnson counter helpers. No dependencies.
package qsd_pkg;

  // Base widths of the datapath.
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int PHASE_WIDTH    = 16;

  // Derived widths.
  localparam int HELD_WIDTH  = SAMPLE_WIDTH + 1;
  localparam int DIFF_WIDTH  = SAMPLE_WIDTH + 2;
  localparam int COEF_WIDTH  = COEF_FRAC_BITS + 1;
  localparam int PROD_WIDTH  = DIFF_WIDTH + COEF_WIDTH + 1;
  localparam int NUM_CAPS    = 4;
  localparam int CAP_IDX_WIDTH = 2;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_MAX1 = (PHASE_WIDTH > COEF_WIDTH) ? PHASE_WIDTH : COEF_WIDTH;
  localparam int CFG_DATA_WIDTH = (CFG_DATA_MAX1 > SAMPLE_WIDTH) ? CFG_DATA_MAX1 : SAMPLE_WIDTH;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [HELD_WIDTH-1:0]   held_t;
  typedef logic signed [DIFF_WIDTH-1:0]   diff_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic [PHASE_WIDTH-1:0]         phase_t;
  typedef logic [COEF_WIDTH-1:0]          coef_t;
  typedef logic [1:0]                     jc_t;
  typedef logic [CAP_IDX_WIDTH-1:0]       cap_idx_t;
  typedef logic [CFG_INDEX_WIDTH-1:0]     cfg_index_t;
  typedef logic [CFG_DATA_WIDTH-1:0]      cfg_data_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LO_PERIOD      = CFG_INDEX_WIDTH'(0),
    REG_LO_EDGE_PHASE  = CFG_INDEX_WIDTH'(1),
    REG_LO_START_PHASE = CFG_INDEX_WIDTH'(2),
    REG_RC_COEFFICIENT = CFG_INDEX_WIDTH'(3),
    REG_INPUT_BIAS     = CFG_INDEX_WIDTH'(4)
  } cfg_reg_t;

  // Register values after reset.
  localparam phase_t  LO_PERIOD_RESET      = PHASE_WIDTH'(4);
  localparam phase_t  LO_EDGE_PHASE_RESET  = '0;
  localparam phase_t  LO_START_PHASE_RESET = '0;
  localparam coef_t   COEF_UNITY           = coef_t'(1) << COEF_FRAC_BITS;
  localparam coef_t   RC_COEFFICIENT_RESET = coef_t'(1) << (COEF_FRAC_BITS - 1);
  localparam sample_t INPUT_BIAS_RESET     = '0;

  // Capacitor slots in the held-value array.
  localparam cap_idx_t CAP_C2 = CAP_IDX_WIDTH'(0);
  localparam cap_idx_t CAP_C3 = CAP_IDX_WIDTH'(1);
  localparam cap_idx_t CAP_C4 = CAP_IDX_WIDTH'(2);
  localparam cap_idx_t CAP_C5 = CAP_IDX_WIDTH'(3);

  // Two-flip-flop Johnson counter: 00 -> 01 -> 11 -> 10 -> 00.
  function automatic jc_t jc_advance(jc_t jc);
    return {jc[0], ~jc[1]};
  endfunction

  // Johnson code to capacitor: 00 C2, 01 C4, 11 C3, 10 C5.
  function automatic cap_idx_t cap_select(jc_t jc);
    return {jc[0] ^ jc[1], jc[1]};
  endfunction

  // Charging fractions above unity act as unity.
  function automatic coef_t coef_clamp(cfg_data_t data);
    coef_t raw;
    raw = data[COEF_WIDTH-1:0];
    return (raw > COEF_UNITY) ? COEF_UNITY : raw;
  endfunction

endpackage

/* src/qsd_sample_if.sv */
// Input channel of the detector: valid/ready handshake carrying one sample per beat.
// Depends on qsd_pkg.
interface qsd_sample_if;
  logic             valid;
  logic             ready;
  qsd_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* src/qsd_result_if.sv */
// Result channel of the detector: four held values and the I/Q differences per beat.
// Depends on qsd_pkg.
interface qsd_result_if;
  logic           valid;
  logic           ready;
  qsd_pkg::held_t held_c2;
  qsd_pkg::held_t held_c3;
  qsd_pkg::held_t held_c4;
  qsd_pkg::held_t held_c5;
  qsd_pkg::diff_t in_phase;
  qsd_pkg::diff_t quadrature;

  modport source (output valid, output held_c2, output held_c3, output held_c4,
                  output held_c5, output in_phase, output quadrature, input ready);
  modport sink   (input valid, input held_c2, input held_c3, input held_c4,
                  input held_c5, input in_phase, input quadrature, output ready);
endinterface

/* src/qsd_cfg_if.sv */
// Configuration write channel: register index and write data per beat.
// Depends on qsd_pkg.
interface qsd_cfg_if;
  logic                valid;
  logic                ready;
  qsd_pkg::cfg_index_t index;
  qsd_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/quadrature_sampling_detector.sv */
// Quadrature sampling detector. Each accepted sample (plus input_bias) charges one of
// four held capacitor values, chosen by a Johnson counter that a local-oscillator phase
// counter clocks once per oscillator period; every sample yields one result beat with
// all four held values and I = C2 - C3, Q = C4 - C5. The block takes one sample per
// clock cycle while the result channel is not stalled, and passes each sample through
// the input register, then the result register. That rate is set by the state loop:
// phase step and compare, Johnson step, capacitor select, one 18x18 multiply and add.
// Configuration writes are always taken; they must arrive while the block is idle, and
// each write to a listed register reloads the start phase and clears the counter and
// the held values. A charging fraction above unity is clamped to unity when written.
// Depends on qsd_pkg, the three channel interfaces and assert_macros.svh.
`include "assert_macros.svh"

module quadrature_sampling_detector (
  input  logic        clk,
  input  logic        rst,
  qsd_sample_if.sink  samples,
  qsd_result_if.source results,
  qsd_cfg_if.sink     cfg
);

  // Configuration registers.
  qsd_pkg::phase_t  lo_period;
  qsd_pkg::phase_t  lo_edge_phase;
  qsd_pkg::phase_t  lo_start_phase;
  qsd_pkg::coef_t   coef;
  qsd_pkg::sample_t input_bias;

  // Detector state.
  qsd_pkg::phase_t  phase;
  qsd_pkg::jc_t     jc;
  qsd_pkg::held_t   held [qsd_pkg::NUM_CAPS];

  // Input register and result handshake.
  logic             s1_valid;
  qsd_pkg::sample_t s1_sample;
  logic             res_valid;
  qsd_pkg::diff_t   in_phase;
  qsd_pkg::diff_t   quadrature;

  // Next-state values.
  qsd_pkg::phase_t  phase_next;
  qsd_pkg::jc_t     jc_next;
  qsd_pkg::held_t   held_next [qsd_pkg::NUM_CAPS];
  qsd_pkg::phase_t  start_phase_next;

  // Datapath intermediates.
  logic                             advance;
  logic                             cfg_restart;
  logic [qsd_pkg::PHASE_WIDTH:0]    phase_inc;
  qsd_pkg::phase_t                  phase_step;
  qsd_pkg::jc_t                     jc_step;
  qsd_pkg::cap_idx_t                sel;
  qsd_pkg::held_t                   target;
  qsd_pkg::held_t                   held_cur;
  qsd_pkg::diff_t                   diff;
  logic signed [qsd_pkg::COEF_WIDTH:0] coef_s;
  qsd_pkg::prod_t                   prod;
  qsd_pkg::prod_t                   charge;
  qsd_pkg::held_t                   held_upd;
  logic [qsd_pkg::NUM_CAPS-1:0]     held_moved;
  logic                             caps_cleared;
  logic                             iq_consistent;

  // Handshakes: the input register moves on whenever the result register is free.
  assign advance       = s1_valid && (!res_valid || results.ready);
  assign samples.ready = !s1_valid || advance;
  assign cfg.ready     = 1'b1;

  // A write to a listed register restarts the detector.
  always_comb begin
    cfg_restart      = 1'b0;
    start_phase_next = lo_start_phase;
    if (cfg.valid) begin
      case (qsd_pkg::cfg_reg_t'(cfg.index))
        qsd_pkg::REG_LO_PERIOD,
        qsd_pkg::REG_LO_EDGE_PHASE,
        qsd_pkg::REG_RC_COEFFICIENT,
        qsd_pkg::REG_INPUT_BIAS: cfg_restart = 1'b1;
        qsd_pkg::REG_LO_START_PHASE: begin
          cfg_restart      = 1'b1;
          start_phase_next = cfg.data[qsd_pkg::PHASE_WIDTH-1:0];
        end
        default: cfg_restart = 1'b0;
      endcase
    end
  end

  // Oscillator phase step and Johnson counter clocking.
  assign phase_inc  = {1'b0, phase} + (qsd_pkg::PHASE_WIDTH + 1)'(1);
  assign phase_step = (phase_inc >= {1'b0, lo_period}) ? '0
                                                       : phase_inc[qsd_pkg::PHASE_WIDTH-1:0];
  assign jc_step    = (phase_step == lo_edge_phase) ? qsd_pkg::jc_advance(jc) : jc;

  // Selected capacitor moves toward the biased sample by the charging fraction.
  assign sel      = qsd_pkg::cap_select(jc_step);
  assign target   = qsd_pkg::held_t'(s1_sample) + qsd_pkg::held_t'(input_bias);
  assign held_cur = held[sel];
  assign diff     = qsd_pkg::diff_t'(target) - qsd_pkg::diff_t'(held_cur);
  assign coef_s   = {1'b0, coef};
  assign prod     = diff * coef_s;
  assign charge   = prod >>> qsd_pkg::COEF_FRAC_BITS;
  // The new value lies between the old value and the target, so it fits the held width.
  assign held_upd = held_cur + qsd_pkg::held_t'(charge);

  // Next state of the phase, the counter and the held values.
  always_comb begin
    phase_next = phase;
    jc_next    = jc;
    for (int i = 0; i < qsd_pkg::NUM_CAPS; i++) begin
      held_next[i] = held[i];
    end
    if (cfg_restart) begin
      phase_next = start_phase_next;
      jc_next    = '0;
      for (int i = 0; i < qsd_pkg::NUM_CAPS; i++) begin
        held_next[i] = '0;
      end
    end else if (advance) begin
      phase_next     = phase_step;
      jc_next        = jc_step;
      held_next[sel] = held_upd;
    end
  end

  always_comb begin
    for (int i = 0; i < qsd_pkg::NUM_CAPS; i++) begin
      held_moved[i] = (held_next[i] != held[i]);
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lo_period      <= qsd_pkg::LO_PERIOD_RESET;
      lo_edge_phase  <= qsd_pkg::LO_EDGE_PHASE_RESET;
      lo_start_phase <= qsd_pkg::LO_START_PHASE_RESET;
      coef           <= qsd_pkg::RC_COEFFICIENT_RESET;
      input_bias     <= qsd_pkg::INPUT_BIAS_RESET;
      phase          <= qsd_pkg::LO_START_PHASE_RESET;
      jc             <= '0;
      for (int i = 0; i < qsd_pkg::NUM_CAPS; i++) begin
        held[i] <= '0;
      end
      s1_valid       <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (qsd_pkg::cfg_reg_t'(cfg.index))
          qsd_pkg::REG_LO_PERIOD:      lo_period     <= cfg.data[qsd_pkg::PHASE_WIDTH-1:0];
          qsd_pkg::REG_LO_EDGE_PHASE:  lo_edge_phase <= cfg.data[qsd_pkg::PHASE_WIDTH-1:0];
          qsd_pkg::REG_LO_START_PHASE: lo_start_phase <= start_phase_next;
          qsd_pkg::REG_RC_COEFFICIENT: coef          <= qsd_pkg::coef_clamp(cfg.data);
          qsd_pkg::REG_INPUT_BIAS:     input_bias    <= cfg.data[qsd_pkg::SAMPLE_WIDTH-1:0];
          default: ;
        endcase
      end
      phase <= phase_next;
      jc    <= jc_next;
      for (int i = 0; i < qsd_pkg::NUM_CAPS; i++) begin
        held[i] <= held_next[i];
      end
      if (samples.valid && samples.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers: the accepted sample and the I/Q differences.
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_sample <= samples.sample;
    end
    if (advance) begin
      in_phase   <= qsd_pkg::diff_t'(held_next[qsd_pkg::CAP_C2])
                  - qsd_pkg::diff_t'(held_next[qsd_pkg::CAP_C3]);
      quadrature <= qsd_pkg::diff_t'(held_next[qsd_pkg::CAP_C4])
                  - qsd_pkg::diff_t'(held_next[qsd_pkg::CAP_C5]);
    end
  end

  // The held registers change only on a beat or a config restart.
  assign results.valid      = res_valid;
  assign results.held_c2    = held[qsd_pkg::CAP_C2];
  assign results.held_c3    = held[qsd_pkg::CAP_C3];
  assign results.held_c4    = held[qsd_pkg::CAP_C4];
  assign results.held_c5    = held[qsd_pkg::CAP_C5];
  assign results.in_phase   = in_phase;
  assign results.quadrature = quadrature;

  // Conditions checked by the assertions below.
  assign caps_cleared  = (jc == '0) && (held[0] == '0) && (held[1] == '0)
                      && (held[2] == '0) && (held[3] == '0);
  assign iq_consistent = (in_phase == qsd_pkg::diff_t'(held[0]) - qsd_pkg::diff_t'(held[1]))
                      && (quadrature == qsd_pkg::diff_t'(held[2]) - qsd_pkg::diff_t'(held[3]));

  // Assertions.
  `QSD_ASSERT(a_restart_clears, cfg_restart |=> caps_cleared)
  `QSD_ASSERT(a_one_cap_moves, !cfg_restart |-> $countones(held_moved) <= 1)
  `QSD_ASSERT(a_phase_in_range, advance && !cfg_restart |=> (phase == '0) || (phase < lo_period))
  `QSD_ASSERT(a_item_kept, s1_valid && !advance && !rst |=> s1_valid)
  `QSD_ASSERT(a_iq_matches, res_valid |-> iq_consistent)

endmodule
